>>> rtl/button_mode_sleep_tick_controller_unit_macros.svh
// Assertion macros used by the checker file of the button controller.
`ifndef BUTTON_MODE_SLEEP_TICK_CONTROLLER_UNIT_MACROS_SVH
`define BUTTON_MODE_SLEEP_TICK_CONTROLLER_UNIT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define BMSTC_ASSERT(name, prop, clk, rst_n, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define BMSTC_ASSERT_ALWAYS(name, prop, clk, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> rtl/bmstc_pkg.sv
// Package: types, codes and reset constants of the button controller.
`default_nettype none

package bmstc_pkg;

  localparam int unsigned NumViewsDefault = 5;
  localparam int unsigned ViewW  = 3;
  localparam int unsigned CountW = 16;
  localparam int unsigned MsW    = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CfgIdxW = 3;

  // Configuration reset values
  localparam logic [CountW-1:0] TempPeriodRst     = 16'd100;
  localparam logic [CountW-1:0] HumidityPeriodRst = 16'd100;
  localparam logic [CountW-1:0] MagnetPeriodRst   = 16'd100;
  localparam logic [CountW-1:0] RangePeriodRst    = 16'd100;
  localparam logic [MsW-1:0]    TickMsRst         = 8'd10;
  localparam logic [CountW-1:0] DebounceMsRst     = 16'd200;
  localparam logic [CountW-1:0] HoldOffMsRst      = 16'd2000;

  // Staggered start values of the sample counters
  localparam logic [CountW-1:0] HumidityCountRst = 16'd10;
  localparam logic [CountW-1:0] MagnetCountRst   = 16'd20;
  localparam logic [CountW-1:0] RangeCountRst    = 16'd30;

  localparam logic [ViewW-1:0] LeftViewRst  = 3'd0;
  localparam logic [ViewW-1:0] RightViewRst = 3'd1;

  typedef enum logic [KindW-1:0] {
    KindTick       = 3'd0,
    KindLeftPress  = 3'd1,
    KindRightPress = 3'd2,
    KindAdcDone    = 3'd3,
    KindWake       = 3'd4
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTempPeriod     = 3'd0,
    CfgHumidityPeriod = 3'd1,
    CfgMagnetPeriod   = 3'd2,
    CfgRangePeriod    = 3'd3,
    CfgTickMs         = 3'd4,
    CfgDebounceMs     = 3'd5,
    CfgHoldOffMs      = 3'd6
  } cfg_idx_e;

endpackage

`default_nettype wire

>>> rtl/button_mode_sleep_tick_controller_unit.sv
// Top level: button debounce, view selection, sample strobes and sleep request.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  event   | in_valid_i/in_ready_o, kind_i, *_released_i     | in
//  result  | out_valid_o/out_ready_i, strobe_*_o, sleep, view| out
//  config  | cfg_we_i, cfg_index_i, cfg_wdata_i              | in
//
// One event beat per cycle sustained while the result is not stalled; each accepted
// event passes the input register, then the result register, before its result beat.
// The state update is a single pass of saturating adds and compares.
// Reset puts all counters, views and config registers at their defaults.
// A stalled result holds; the input register still fills behind it.
`default_nettype none

module button_mode_sleep_tick_controller_unit #(
  parameter int unsigned NUM_VIEWS = bmstc_pkg::NumViewsDefault
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // event channel
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [bmstc_pkg::KindW-1:0]      kind_i,
  input  wire                              left_released_i,
  input  wire                              right_released_i,
  // result channel
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             strobe_temp_o,
  output logic                             strobe_humidity_o,
  output logic                             strobe_magnet_o,
  output logic                             strobe_range_o,
  output logic                             sleep_request_o,
  output logic [bmstc_pkg::ViewW-1:0]      left_view_o,
  output logic [bmstc_pkg::ViewW-1:0]      right_view_o,
  // configuration write port
  input  wire                              cfg_we_i,
  input  wire  [bmstc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [bmstc_pkg::CountW-1:0]     cfg_wdata_i
);
  import bmstc_pkg::*;

  localparam logic [ViewW-1:0] LastView = ViewW'(NUM_VIEWS - 1);
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  function automatic logic [ViewW-1:0] next_view(input logic [ViewW-1:0] v);
    return (v == LastView) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    return (c == CountMax) ? CountMax : c + 1'b1;
  endfunction

  function automatic logic [CountW-1:0] sat_add_ms(input logic [CountW-1:0] c,
                                                   input logic [MsW-1:0] ms);
    logic [CountW:0] s;
    s = {1'b0, c} + {{(CountW + 1 - MsW){1'b0}}, ms};
    return s[CountW] ? CountMax : s[CountW-1:0];
  endfunction

  // ---------------- configuration registers ----------------
  logic [CountW-1:0] temp_period_q, humidity_period_q, magnet_period_q, range_period_q;
  logic [MsW-1:0]    tick_ms_q;
  logic [CountW-1:0] debounce_ms_q, hold_off_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_period_q     <= TempPeriodRst;
      humidity_period_q <= HumidityPeriodRst;
      magnet_period_q   <= MagnetPeriodRst;
      range_period_q    <= RangePeriodRst;
      tick_ms_q         <= TickMsRst;
      debounce_ms_q     <= DebounceMsRst;
      hold_off_ms_q     <= HoldOffMsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgTempPeriod:     temp_period_q     <= cfg_wdata_i;
        CfgHumidityPeriod: humidity_period_q <= cfg_wdata_i;
        CfgMagnetPeriod:   magnet_period_q   <= cfg_wdata_i;
        CfgRangePeriod:    range_period_q    <= cfg_wdata_i;
        CfgTickMs:         tick_ms_q         <= cfg_wdata_i[MsW-1:0];
        CfgDebounceMs:     debounce_ms_q     <= cfg_wdata_i;
        CfgHoldOffMs:      hold_off_ms_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic  s1_valid_q, s1_valid_d;
  kind_e s1_kind_q;
  logic  s1_lrel_q, s1_rrel_q;
  logic  out_valid_q, out_valid_d;
  logic  out_free, s1_fire, in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // valid bits of the input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= kind_e'(kind_i);
      s1_lrel_q <= left_released_i;
      s1_rrel_q <= right_released_i;
    end
  end

  // ---------------- controller state ----------------
  logic [ViewW-1:0]  left_index_q, left_index_d, right_index_q, right_index_d;
  logic              left_deb_q, left_deb_d, right_deb_q, right_deb_d;
  logic [CountW-1:0] left_deb_cnt_q, left_deb_cnt_d, right_deb_cnt_q, right_deb_cnt_d;
  logic              left_eng_q, left_eng_d, right_eng_q, right_eng_d;
  logic [CountW-1:0] left_hold_q, left_hold_d, right_hold_q, right_hold_d;
  logic [CountW-1:0] temp_cnt_q, temp_cnt_d, hum_cnt_q, hum_cnt_d;
  logic [CountW-1:0] mag_cnt_q, mag_cnt_d, range_cnt_q, range_cnt_d;
  logic              conv_ready_q, conv_ready_d;
  logic              sleep_q, sleep_d;
  logic              st_d, sh_d, sm_d, sr_d;

  // candidate values for a tick
  logic [CountW-1:0] temp_inc, hum_inc, mag_inc, range_inc;
  logic [CountW-1:0] left_hold_inc, right_hold_inc, left_deb_inc, right_deb_inc;
  logic [ViewW-1:0]  left_step, right_step;

  assign temp_inc       = sat_inc(temp_cnt_q);
  assign hum_inc        = sat_inc(hum_cnt_q);
  assign mag_inc        = sat_inc(mag_cnt_q);
  assign range_inc      = sat_inc(range_cnt_q);
  assign left_hold_inc  = sat_add_ms(left_hold_q, tick_ms_q);
  assign right_hold_inc = sat_add_ms(right_hold_q, tick_ms_q);
  assign left_deb_inc   = sat_add_ms(left_deb_cnt_q, tick_ms_q);
  assign right_deb_inc  = sat_add_ms(right_deb_cnt_q, tick_ms_q);
  assign left_step      = next_view(left_index_q);
  assign right_step     = next_view(right_index_q);

  // next-state logic for one event
  always_comb begin
    left_index_d    = left_index_q;
    right_index_d   = right_index_q;
    left_deb_d      = left_deb_q;
    right_deb_d     = right_deb_q;
    left_deb_cnt_d  = left_deb_cnt_q;
    right_deb_cnt_d = right_deb_cnt_q;
    left_eng_d      = left_eng_q;
    right_eng_d     = right_eng_q;
    left_hold_d     = left_hold_q;
    right_hold_d    = right_hold_q;
    temp_cnt_d      = temp_cnt_q;
    hum_cnt_d       = hum_cnt_q;
    mag_cnt_d       = mag_cnt_q;
    range_cnt_d     = range_cnt_q;
    conv_ready_d    = conv_ready_q;
    sleep_d         = sleep_q;
    st_d = 1'b0;
    sh_d = 1'b0;
    sm_d = 1'b0;
    sr_d = 1'b0;
    if (s1_fire) begin
      case (s1_kind_q)
        KindTick: begin
          // sample period counters
          if (temp_inc > temp_period_q) begin
            temp_cnt_d = '0;
            st_d = 1'b1;
          end else begin
            temp_cnt_d = temp_inc;
          end
          if (hum_inc > humidity_period_q) begin
            hum_cnt_d = '0;
            sh_d = 1'b1;
          end else begin
            hum_cnt_d = hum_inc;
          end
          if (mag_inc > magnet_period_q) begin
            mag_cnt_d = '0;
            sm_d = 1'b1;
          end else begin
            mag_cnt_d = mag_inc;
          end
          if (range_inc > range_period_q && conv_ready_q) begin
            range_cnt_d  = '0;
            conv_ready_d = 1'b0;
            sr_d = 1'b1;
          end else begin
            range_cnt_d = range_inc;
          end
          // long-hold timing on engaged buttons
          if (left_eng_q) begin
            if (s1_lrel_q) begin
              left_eng_d  = 1'b0;
              left_hold_d = '0;
            end else if (left_hold_inc >= hold_off_ms_q) begin
              sleep_d     = 1'b1;
              left_hold_d = '0;
              left_eng_d  = 1'b0;
            end else begin
              left_hold_d = left_hold_inc;
            end
          end
          if (right_eng_q) begin
            if (s1_rrel_q) begin
              right_eng_d  = 1'b0;
              right_hold_d = '0;
            end else if (right_hold_inc >= hold_off_ms_q) begin
              sleep_d      = 1'b1;
              right_hold_d = '0;
              right_eng_d  = 1'b0;
            end else begin
              right_hold_d = right_hold_inc;
            end
          end
          // debounce windows; they engage the button for hold timing
          if (left_deb_q) begin
            left_eng_d = 1'b1;
            if (left_deb_inc >= debounce_ms_q) begin
              left_deb_d     = 1'b0;
              left_deb_cnt_d = '0;
            end else begin
              left_deb_cnt_d = left_deb_inc;
            end
          end
          if (right_deb_q) begin
            right_eng_d = 1'b1;
            if (right_deb_inc >= debounce_ms_q) begin
              right_deb_d     = 1'b0;
              right_deb_cnt_d = '0;
            end else begin
              right_deb_cnt_d = right_deb_inc;
            end
          end
        end
        KindLeftPress: begin
          if (!left_deb_q) begin
            left_index_d = (left_step == right_index_q) ? next_view(left_step) : left_step;
            left_deb_d   = 1'b1;
          end
        end
        KindRightPress: begin
          if (!right_deb_q) begin
            right_index_d = (right_step == left_index_q) ? next_view(right_step) : right_step;
            right_deb_d   = 1'b1;
          end
        end
        KindAdcDone: begin
          conv_ready_d = 1'b1;
        end
        KindWake: begin
          sleep_d         = 1'b0;
          left_deb_d      = 1'b1;
          right_deb_d     = 1'b1;
          left_deb_cnt_d  = '0;
          right_deb_cnt_d = '0;
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_index_q    <= LeftViewRst;
      right_index_q   <= RightViewRst;
      left_deb_q      <= 1'b0;
      right_deb_q     <= 1'b0;
      left_deb_cnt_q  <= '0;
      right_deb_cnt_q <= '0;
      left_eng_q      <= 1'b0;
      right_eng_q     <= 1'b0;
      left_hold_q     <= '0;
      right_hold_q    <= '0;
      temp_cnt_q      <= '0;
      hum_cnt_q       <= HumidityCountRst;
      mag_cnt_q       <= MagnetCountRst;
      range_cnt_q     <= RangeCountRst;
      conv_ready_q    <= 1'b0;
      sleep_q         <= 1'b1;
    end else begin
      left_index_q    <= left_index_d;
      right_index_q   <= right_index_d;
      left_deb_q      <= left_deb_d;
      right_deb_q     <= right_deb_d;
      left_deb_cnt_q  <= left_deb_cnt_d;
      right_deb_cnt_q <= right_deb_cnt_d;
      left_eng_q      <= left_eng_d;
      right_eng_q     <= right_eng_d;
      left_hold_q     <= left_hold_d;
      right_hold_q    <= right_hold_d;
      temp_cnt_q      <= temp_cnt_d;
      hum_cnt_q       <= hum_cnt_d;
      mag_cnt_q       <= mag_cnt_d;
      range_cnt_q     <= range_cnt_d;
      conv_ready_q    <= conv_ready_d;
      sleep_q         <= sleep_d;
    end
  end

  // result register
  logic              res_st_q, res_sh_q, res_sm_q, res_sr_q, res_sleep_q;
  logic [ViewW-1:0]  res_left_q, res_right_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_st_q    <= st_d;
      res_sh_q    <= sh_d;
      res_sm_q    <= sm_d;
      res_sr_q    <= sr_d;
      res_sleep_q <= sleep_d;
      res_left_q  <= left_index_d;
      res_right_q <= right_index_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign strobe_temp_o     = res_st_q;
  assign strobe_humidity_o = res_sh_q;
  assign strobe_magnet_o   = res_sm_q;
  assign strobe_range_o    = res_sr_q;
  assign sleep_request_o   = res_sleep_q;
  assign left_view_o       = res_left_q;
  assign right_view_o      = res_right_q;

endmodule

`default_nettype wire

>>> rtl/bmstc_checker.sv
// Port-level checker for the button controller, with its bind statement.
`default_nettype none
`include "button_mode_sleep_tick_controller_unit_macros.svh"

module bmstc_checker #(
  parameter int unsigned NumViews = bmstc_pkg::NumViewsDefault
) (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           in_valid_i,
  input wire                           in_ready_o,
  input wire                           out_valid_o,
  input wire                           out_ready_i,
  input wire                           strobe_temp_o,
  input wire                           strobe_humidity_o,
  input wire                           strobe_magnet_o,
  input wire                           strobe_range_o,
  input wire                           sleep_request_o,
  input wire [bmstc_pkg::ViewW-1:0]    left_view_o,
  input wire [bmstc_pkg::ViewW-1:0]    right_view_o
);
  import bmstc_pkg::*;

  logic                  out_stall;
  logic [4+2*ViewW:0]    out_beat;
  logic                  views_ok;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_beat  = {strobe_temp_o, strobe_humidity_o, strobe_magnet_o, strobe_range_o,
                      sleep_request_o, left_view_o, right_view_o};
  assign views_ok  = ({1'b0, left_view_o} < (ViewW + 1)'(NumViews)) &&
                     ({1'b0, right_view_o} < (ViewW + 1)'(NumViews));

  // a stalled result beat holds
  `BMSTC_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_beat), clk_i, rst_ni, "result beat changed while stalled")
  // while a result is valid, both sides show distinct, valid views
  `BMSTC_ASSERT(a_views_differ, out_valid_o |-> left_view_o != right_view_o, clk_i, rst_ni, "left and right views collide")
  `BMSTC_ASSERT(a_views_range, out_valid_o |-> views_ok, clk_i, rst_ni, "view index out of range")
  // an empty output always lets a new event in
  `BMSTC_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_o |-> in_ready_o, clk_i, "event stalled with empty output")

endmodule

bind button_mode_sleep_tick_controller_unit bmstc_checker #(
  .NumViews(NUM_VIEWS)
) u_bmstc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .strobe_temp_o    (strobe_temp_o),
  .strobe_humidity_o(strobe_humidity_o),
  .strobe_magnet_o  (strobe_magnet_o),
  .strobe_range_o   (strobe_range_o),
  .sleep_request_o  (sleep_request_o),
  .left_view_o      (left_view_o),
  .right_view_o     (right_view_o)
);

`default_nettype wire

>>> bench/tb_button_mode_sleep_tick_controller_unit.sv
// Testbench of the button controller: scoreboard with predictor, event and result drivers.
`timescale 1ns / 1ps

module tb_button_mode_sleep_tick_controller_unit;
  import bmstc_pkg::*;

  localparam int unsigned NumViews   = NumViewsDefault;
  localparam int unsigned CycleLimit = 400000;

  // One result beat as seen on the output ports
  typedef struct packed {
    logic             strobe_temp;
    logic             strobe_humidity;
    logic             strobe_magnet;
    logic             strobe_range;
    logic             sleep_request;
    logic [ViewW-1:0] left_view;
    logic [ViewW-1:0] right_view;
  } result_t;

  // Predicts the result of each accepted event and checks the beats in order
  class view_sleep_scoreboard;
    // register copy
    bit [CountW-1:0] temp_period, humidity_period, magnet_period, range_period;
    bit [MsW-1:0]    tick_ms;
    bit [CountW-1:0] debounce_ms, hold_off_ms;
    // block state
    bit [ViewW-1:0]  left_idx, right_idx;
    bit              left_deb, right_deb, left_eng, right_eng;
    bit [CountW-1:0] left_deb_cnt, right_deb_cnt, left_hold, right_hold;
    bit [CountW-1:0] temp_cnt, hum_cnt, mag_cnt, rng_cnt;
    bit              conv_ready, sleep_flag;
    result_t         expected_q[$];
    int unsigned     fails;

    function new();
      temp_period = TempPeriodRst;  humidity_period = HumidityPeriodRst;
      magnet_period = MagnetPeriodRst;  range_period = RangePeriodRst;
      tick_ms = TickMsRst;  debounce_ms = DebounceMsRst;  hold_off_ms = HoldOffMsRst;
      left_idx = LeftViewRst;  right_idx = RightViewRst;
      left_deb = 1'b0;  right_deb = 1'b0;  left_eng = 1'b0;  right_eng = 1'b0;
      left_deb_cnt = '0;  right_deb_cnt = '0;  left_hold = '0;  right_hold = '0;
      temp_cnt = '0;  hum_cnt = HumidityCountRst;
      mag_cnt = MagnetCountRst;  rng_cnt = RangeCountRst;
      conv_ready = 1'b0;
      sleep_flag = 1'b1;
      fails = 0;
    endfunction

    function void write_setting(cfg_idx_e idx, bit [CountW-1:0] value);
      case (idx)
        CfgTempPeriod:     temp_period = value;
        CfgHumidityPeriod: humidity_period = value;
        CfgMagnetPeriod:   magnet_period = value;
        CfgRangePeriod:    range_period = value;
        CfgTickMs:         tick_ms = value[MsW-1:0];
        CfgDebounceMs:     debounce_ms = value;
        CfgHoldOffMs:      hold_off_ms = value;
        default: ;
      endcase
    endfunction

    function bit [CountW-1:0] sat_add(bit [CountW-1:0] a, bit [CountW-1:0] b);
      bit [CountW:0] s;
      s = {1'b0, a} + b;
      return s[CountW] ? '1 : s[CountW-1:0];
    endfunction

    function bit [ViewW-1:0] next_view(bit [ViewW-1:0] v);
      return ViewW'((int'(v) + 1) % NumViews);
    endfunction

    // returns {strobe, new count}
    function bit [CountW:0] advance_period(bit [CountW-1:0] cnt, bit [CountW-1:0] period);
      bit [CountW-1:0] nxt;
      nxt = sat_add(cnt, 16'd1);
      if (nxt > period) return {1'b1, {CountW{1'b0}}};
      return {1'b0, nxt};
    endfunction

    // long hold of an engaged button raises sleep
    function void hold_step(inout bit eng, inout bit [CountW-1:0] hold, input bit released);
      if (!eng) return;
      if (released) begin
        eng = 1'b0;
        hold = '0;
      end else begin
        hold = sat_add(hold, {8'd0, tick_ms});
        if (hold >= hold_off_ms) begin
          sleep_flag = 1'b1;
          hold = '0;
          eng = 1'b0;
        end
      end
    endfunction

    function void debounce_step(inout bit deb, inout bit [CountW-1:0] cnt, inout bit eng);
      if (!deb) return;
      eng = 1'b1;
      cnt = sat_add(cnt, {8'd0, tick_ms});
      if (cnt >= debounce_ms) begin
        deb = 1'b0;
        cnt = '0;
      end
    endfunction

    // accepted event beat: update state, queue the expected result
    function void note_event(bit [KindW-1:0] kind, bit left_rel, bit right_rel);
      result_t exp;
      bit [CountW:0] step;
      exp = '0;
      case (kind)
        KindTick: begin
          step = advance_period(temp_cnt, temp_period);
          {exp.strobe_temp, temp_cnt} = step;
          step = advance_period(hum_cnt, humidity_period);
          {exp.strobe_humidity, hum_cnt} = step;
          step = advance_period(mag_cnt, magnet_period);
          {exp.strobe_magnet, mag_cnt} = step;
          rng_cnt = sat_add(rng_cnt, 16'd1);
          if (rng_cnt > range_period && conv_ready) begin
            conv_ready = 1'b0;
            rng_cnt = '0;
            exp.strobe_range = 1'b1;
          end
          hold_step(left_eng, left_hold, left_rel);
          hold_step(right_eng, right_hold, right_rel);
          debounce_step(left_deb, left_deb_cnt, left_eng);
          debounce_step(right_deb, right_deb_cnt, right_eng);
        end
        KindLeftPress: begin
          if (!left_deb) begin
            left_idx = next_view(left_idx);
            if (left_idx == right_idx) left_idx = next_view(left_idx);
            left_deb = 1'b1;
          end
        end
        KindRightPress: begin
          if (!right_deb) begin
            right_idx = next_view(right_idx);
            if (left_idx == right_idx) right_idx = next_view(right_idx);
            right_deb = 1'b1;
          end
        end
        KindAdcDone: conv_ready = 1'b1;
        KindWake: begin
          sleep_flag = 1'b0;
          left_deb = 1'b1;
          right_deb = 1'b1;
          left_deb_cnt = '0;
          right_deb_cnt = '0;
        end
        default: ;
      endcase
      exp.sleep_request = sleep_flag;
      exp.left_view = left_idx;
      exp.right_view = right_idx;
      expected_q.push_back(exp);
    endfunction

    function void check_field(string name, logic [ViewW-1:0] exp, logic [ViewW-1:0] act);
      if (act !== exp) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        fails++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        $error("result beat with no event waiting for it");
        fails++;
        return;
      end
      exp = expected_q.pop_front();
      check_field("strobe_temp", exp.strobe_temp, got.strobe_temp);
      check_field("strobe_humidity", exp.strobe_humidity, got.strobe_humidity);
      check_field("strobe_magnet", exp.strobe_magnet, got.strobe_magnet);
      check_field("strobe_range", exp.strobe_range, got.strobe_range);
      check_field("sleep_request", exp.sleep_request, got.sleep_request);
      check_field("left_view", exp.left_view, got.left_view);
      check_field("right_view", exp.right_view, got.right_view);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [KindW-1:0]    kind_i = '0;
  logic                left_released_i = 1'b1;
  logic                right_released_i = 1'b1;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                strobe_temp_o, strobe_humidity_o, strobe_magnet_o, strobe_range_o;
  logic                sleep_request_o;
  logic [ViewW-1:0]    left_view_o, right_view_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CountW-1:0]   cfg_wdata_i = '0;

  view_sleep_scoreboard sb;
  bit                   calm = 1'b0;     // no idling on either side
  int unsigned          stall_req = 0;   // long receiver hold-off, in cycles
  int unsigned          cycle_count = 0;

  button_mode_sleep_tick_controller_unit #(.NUM_VIEWS(NumViews)) dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .kind_i, .left_released_i, .right_released_i,
    .out_valid_o, .out_ready_i,
    .strobe_temp_o, .strobe_humidity_o, .strobe_magnet_o, .strobe_range_o,
    .sleep_request_o, .left_view_o, .right_view_o,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Beat monitor: both channels sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_event(kind_i, left_released_i, right_released_i);
      if (out_valid_o && out_ready_i)
        sb.check_result({strobe_temp_o, strobe_humidity_o, strobe_magnet_o, strobe_range_o,
                         sleep_request_o, left_view_o, right_view_o});
    end
  end

  // Result receiver: random stalls plus the occasional long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_req != 0) begin
        hold_left = stall_req;
        stall_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  // Random pin level
  function automatic bit coin();
    return 1'($urandom_range(1));
  endfunction

  // Offer one event beat and wait until it is taken; entered and left at a falling edge
  task automatic send_event(input bit [KindW-1:0] kind, input bit left_rel, input bit right_rel);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    left_released_i <= left_rel;
    right_released_i <= right_rel;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_reg(input cfg_idx_e idx, input bit [CountW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    sb.write_setting(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input bit [CountW-1:0] tp, hp, mp, rp, tick, deb, hold);
    program_reg(CfgTempPeriod, tp);
    program_reg(CfgHumidityPeriod, hp);
    program_reg(CfgMagnetPeriod, mp);
    program_reg(CfgRangePeriod, rp);
    program_reg(CfgTickMs, tick);
    program_reg(CfgDebounceMs, deb);
    program_reg(CfgHoldOffMs, hold);
  endtask

  // Stop offering events and let every outstanding result come back
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Press-and-hold sequences with random content in under half of the rounds, loose events in the rest
  task automatic run_traffic(input int unsigned budget);
    int unsigned sent, need, span, i, roll;
    bit side;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 45) begin
        side = coin();
        if (sb.tick_ms == 0) need = 20;
        else need = (int'(sb.debounce_ms) + int'(sb.hold_off_ms)) / int'(sb.tick_ms) + 3;
        if (need > 600) need = 600;
        // keep the sequence inside what is left of the budget
        if (sent + need + 2 > budget) need = (budget > sent + 3) ? budget - sent - 2 : 1;
        span = $urandom_range(1) ? need : $urandom_range(1, need);
        send_event(side ? KindRightPress : KindLeftPress, coin(), coin());
        for (i = 0; i < span; i++) begin
          roll = $urandom_range(99);
          if (roll < 5)
            send_event(KindAdcDone, coin(), coin());
          else if (roll < 8)
            send_event(side ? KindLeftPress : KindRightPress, coin(), coin());
          else if (side)
            send_event(KindTick, coin(), 1'b0);
          else
            send_event(KindTick, 1'b0, coin());
        end
        // let go of the button
        send_event(KindTick, side ? coin() : 1'b1, side ? 1'b1 : coin());
        sent += span + 2;
      end else begin
        roll = $urandom_range(99);
        if (roll < 50)      send_event(KindTick, coin(), coin());
        else if (roll < 62) send_event(KindLeftPress, coin(), coin());
        else if (roll < 74) send_event(KindRightPress, coin(), coin());
        else if (roll < 86) send_event(KindAdcDone, coin(), coin());
        else if (roll < 93) send_event(KindWake, coin(), coin());
        else send_event(KindW'($urandom_range(5, 7)), coin(), coin());
        sent++;
      end
    end
  endtask

  // Main sequence
  initial begin : stimulus
    sb = new();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed events at the reset settings
    send_event(KindTick, 1'b1, 1'b1);
    send_event(KindTick, 1'b0, 1'b0);
    send_event(KindLeftPress, 1'b1, 1'b1);   // skips over the right view
    send_event(KindLeftPress, 1'b0, 1'b0);   // ignored while debouncing
    send_event(KindRightPress, 1'b1, 1'b1);  // skips over the left view
    send_event(KindRightPress, 1'b0, 1'b1);
    send_event(KindAdcDone, 1'b1, 1'b0);
    send_event(KindWake, 1'b0, 1'b0);        // sleep request drops
    send_event(3'd5, 1'b0, 1'b0);            // unused kinds change nothing
    send_event(3'd6, 1'b1, 1'b1);
    send_event(3'd7, 1'b0, 1'b1);
    send_event(KindTick, 1'b0, 1'b0);        // debounce engages both buttons
    send_event(KindTick, 1'b0, 1'b1);
    send_event(KindTick, 1'b1, 1'b0);
    send_event(KindWake, 1'b1, 1'b1);
    send_event(KindLeftPress, 1'b1, 1'b1);
    send_event(KindAdcDone, 1'b0, 1'b0);
    send_event(KindTick, 1'b1, 1'b1);

    stall_req = 120;
    run_traffic(200);
    settle_block();

    // fastest everything: temperature strobe every tick, short other periods, zero windows
    apply_setting(16'd0, 16'd1, 16'd2, 16'd3, 16'h0001, 16'd0, 16'd0);
    stall_req = 150;
    run_traffic(220);
    settle_block();

    // saturating windows, periods that never strobe; no idling at all
    calm = 1'b1;
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(420);
    settle_block();
    calm = 1'b0;

    // zero tick step: debounce and hold counts never advance
    apply_setting(16'd5, 16'd0, 16'd7, 16'd2, 16'hA500, 16'd0, 16'd40);
    run_traffic(180);
    settle_block();

    repeat (2) begin
      apply_setting(16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
                    16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
                    {8'($urandom), 8'($urandom_range(1, 60))},
                    16'($urandom_range(0, 400)), 16'($urandom_range(0, 1500)));
      stall_req = 60;
      run_traffic(180);
      settle_block();
    end

    apply_setting(TempPeriodRst, HumidityPeriodRst, MagnetPeriodRst, RangePeriodRst,
                  {8'd0, TickMsRst}, DebounceMsRst, HoldOffMsRst);
    run_traffic(150);
    settle_block();

    repeat (8) @(negedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/bmstc_pkg.sv
rtl/button_mode_sleep_tick_controller_unit.sv
rtl/bmstc_checker.sv
bench/tb_button_mode_sleep_tick_controller_unit.sv
